/* hdl/pcb_pkg.sv */
// Package for the pixel cross-fade blend: item types, weight constants.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pcb_pkg;

	localparam int unsigned WW = 13;          // weight bits, Q0.12 with room for 1.0
	localparam int unsigned CUBE_W = 3 * WW;  // full width of u*u*u
	localparam logic [WW-1:0] ONE_Q12 = 13'd4096;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic signed [15:0] blend_weight;
		logic               ease_cubic;
		logic [7:0]         first_red;
		logic [7:0]         first_green;
		logic [7:0]         first_blue;
		logic [7:0]         second_red;
		logic [7:0]         second_green;
		logic [7:0]         second_blue;
	} pix_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} mix_item_t;

	// Weight with both pixels, as handed from the weight pipeline to the lanes.
	typedef struct packed {
		logic [WW-1:0] alpha;
		rgb_t          first;
		rgb_t          second;
	} wgt_item_t;

endpackage

/* hdl/pcb_weight.sv */
// Weight pipeline: clamps the Q4.12 weight, applies the ease-in-out cubic if ease_cubic.
// Depends on pcb_pkg. Four stages, each advancing when the next one is free.
`timescale 1ns / 1ps

module pcb_weight (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pcb_pkg::pix_item_t in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output pcb_pkg::wgt_item_t out_item
);
	import pcb_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic ld1, ld2, ld3, ld4;

	logic [WW-1:0]     x_s1, u_s1;
	logic              ease_s1, hi_s1;
	rgb_t              f_s1, s_s1;
	logic [2*WW-1:0]   sq_s2;
	logic [WW-1:0]     x_s2, u_s2;
	logic              ease_s2, hi_s2;
	rgb_t              f_s2, s_s2;
	logic [CUBE_W-1:0] cube_s3;
	logic [WW-1:0]     x_s3;
	logic              ease_s3, hi_s3;
	rgb_t              f_s3, s_s3;
	logic [WW-1:0]     a_s4;
	rgb_t              f_s4, s_s4;

	logic [WW-1:0] x_c, t_c, a_c;
	logic          hi_c;

	assign ld4 = !v_s4 || !out_stall;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;
	assign in_stall = !ld1;

	always_comb begin
		if (in_item.blend_weight[15]) begin
			x_c = '0;
		end else if (in_item.blend_weight[14:0] > 15'(ONE_Q12)) begin
			x_c = ONE_Q12;
		end else begin
			x_c = in_item.blend_weight[WW-1:0];
		end
		hi_c = x_c[WW-1] | x_c[WW-2];
		// Upper half uses t = 2 - 2x, which stays within 0..1.
		t_c = WW'((ONE_Q12 << 1) - {x_c, 1'b0});
	end

	// Lower half: 4x^3 in Q0.12 is x^3 >> 22; upper half: 1 - t^3 >> 25.
	always_comb begin
		if (!ease_s3) begin
			a_c = x_s3;
		end else if (hi_s3) begin
			a_c = ONE_Q12 - cube_s3[WW+24:25];
		end else begin
			a_c = cube_s3[WW+21:22];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			x_s1    <= x_c;
			u_s1    <= hi_c ? t_c : x_c;
			hi_s1   <= hi_c;
			ease_s1 <= in_item.ease_cubic;
			f_s1    <= '{in_item.first_red, in_item.first_green, in_item.first_blue};
			s_s1    <= '{in_item.second_red, in_item.second_green, in_item.second_blue};
		end
		if (ld2) begin
			sq_s2   <= u_s1 * u_s1;
			x_s2    <= x_s1;
			u_s2    <= u_s1;
			hi_s2   <= hi_s1;
			ease_s2 <= ease_s1;
			f_s2    <= f_s1;
			s_s2    <= s_s1;
		end
		if (ld3) begin
			cube_s3 <= sq_s2 * u_s2;
			x_s3    <= x_s2;
			hi_s3   <= hi_s2;
			ease_s3 <= ease_s2;
			f_s3    <= f_s2;
			s_s3    <= s_s2;
		end
		if (ld4) begin
			a_s4 <= a_c;
			f_s4 <= f_s3;
			s_s4 <= s_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_item  = '{alpha: a_s4, first: f_s4, second: s_s4};

`ifndef SYNTHESIS
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> a_s4 <= ONE_Q12)
		else $error("blend weight above one");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !ld2) |=> (v_s1 && $stable(u_s1) && $stable(x_s1)))
		else $error("stage 1 item lost while blocked");
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("pipeline stalls with free output");
`endif

endmodule

/* hdl/pcb_lane.sv */
// One color lane: second + a*(first - second) in Q0.12, truncated to 8 bits.
// Depends on pcb_pkg for the weight width.
`timescale 1ns / 1ps

module pcb_lane (
	input  logic [pcb_pkg::WW-1:0] alpha,
	input  logic [7:0]             first,
	input  logic [7:0]             second,
	output logic [7:0]             mixed
);
	import pcb_pkg::*;

	logic signed [8:0]  diff;
	logic signed [22:0] prod;
	logic signed [22:0] sum;

	// a*f + (1-a)*s rewritten as s*4096 + a*(f-s), one multiplier per lane.
	// Both factors are extended to the full product width before multiplying.
	assign diff  = $signed({1'b0, first}) - $signed({1'b0, second});
	assign prod  = $signed({{(23-WW){1'b0}}, alpha}) * $signed({{14{diff[8]}}, diff});
	assign sum   = $signed({3'b000, second, 12'h000}) + prod;
	assign mixed = sum[19:12];

endmodule

/* hdl/pixel_crossfade_blend_top.sv */
// Top level of the pixel cross-fade blend: weight pipeline, three color lanes
// and the merging output register. Depends on pcb_pkg, pcb_weight, pcb_lane.
//
// channel  direction  handshake                 payload
// pix      in         pix_valid / pix_stall     pix_item (pcb_pkg::pix_item_t)
// mix      out        mix_valid / mix_stall     mix_item (pcb_pkg::mix_item_t)
//
// One item per clock is sustained while mix_stall is low; each passes through
// four weight pipeline stages (clamp, square, cube, ease select), then the
// combinational lane multipliers and the output register that drives mix_valid.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stalled output holds its item while empty stages further back keep filling.
`timescale 1ns / 1ps

module pixel_crossfade_blend_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  pcb_pkg::pix_item_t pix_item,
	output logic               mix_valid,
	input  logic               mix_stall,
	output pcb_pkg::mix_item_t mix_item
);
	import pcb_pkg::*;

	logic      w_valid, w_stall, ld_s5;
	wgt_item_t w_item;
	rgb_t      mixed;
	logic      v_s5;
	mix_item_t item_s5;

	pcb_weight u_weight (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_valid),
		.in_stall (pix_stall),
		.in_item  (pix_item),
		.out_valid(w_valid),
		.out_stall(w_stall),
		.out_item (w_item)
	);

	pcb_lane u_lane_red (
		.alpha (w_item.alpha),
		.first (w_item.first.red),
		.second(w_item.second.red),
		.mixed (mixed.red)
	);

	pcb_lane u_lane_green (
		.alpha (w_item.alpha),
		.first (w_item.first.green),
		.second(w_item.second.green),
		.mixed (mixed.green)
	);

	pcb_lane u_lane_blue (
		.alpha (w_item.alpha),
		.first (w_item.first.blue),
		.second(w_item.second.blue),
		.mixed (mixed.blue)
	);

	assign ld_s5   = !v_s5 || !mix_stall;
	assign w_stall = !ld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (ld_s5) begin
			v_s5 <= w_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			item_s5 <= '{out_red: mixed.red, out_green: mixed.green, out_blue: mixed.blue};
		end
	end

	assign mix_valid = v_s5;
	assign mix_item  = item_s5;

endmodule
